@@ hdl/edma_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, reset values and register indexes for the echo distance
// moving average core. No dependencies.
package edma_pkg;

	localparam int ECHO_W    = 16;
	localparam int CM_W      = 10;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 1;
	localparam int DIV_CNT_W = $clog2(ECHO_W);
	localparam int OUT_W     = 24;

	localparam logic [CFG_W-1:0] TICKS_RESET = 10'd117;
	localparam logic [CFG_W-1:0] RANGE_RESET = 10'd400;

	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_CM = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE_CM = 1'd1;

endpackage

@@ hdl/edma_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package dependency.
module edma_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 5,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/echo_distance_moving_average_core.sv @@
`timescale 1ns / 1ps
// Ultrasonic echo to distance converter with a moving average window.
// Uses edma_pkg and one edma_ram instance holding the window.
//
// Usage:
//   s_tdata carries one echo length in timer ticks per beat. Each beat gives
//   one m_tdata beat with the distance in cm and the truncated mean of the
//   last WINDOW_LEN distances (fewer right after reset).
//   The cfg port writes ticks_per_cm (index 0) and max_range_cm (index 1);
//   write only while the core is idle.
// Timing:
//   One shared restoring divider, one quotient bit per cycle, does both the
//   tick to cm conversion and the averaging; the window sits in a RAM with a
//   registered read. An accepted beat passes the cm division, the window read,
//   the sum update, the average division and the done state before m_tvalid
//   rises; s_tready returns in the same cycle, and no new beat is taken before.
// Reset and stalls:
//   arst_n clears the window fill count, running sum and write slot and
//   restores the register defaults. The output beat sits in a register, so
//   the next input beat is accepted and processed while m_tready is low; only
//   the delivery of the following result waits for the register to drain.
module echo_distance_moving_average_core #(
	parameter int WINDOW_LEN = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [edma_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [edma_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [edma_pkg::ECHO_W-1:0]      s_tdata,   // [15:0] echo_ticks
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [edma_pkg::OUT_W-1:0]       m_tdata    // [9:0] raw_cm, [19:10] average_cm
);
	localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
	localparam int SUM_W  = $clog2(WINDOW_LEN * 1023 + 1);
	localparam int ECHO_W = edma_pkg::ECHO_W;
	localparam int CM_W   = edma_pkg::CM_W;
	localparam int DCW    = edma_pkg::DIV_CNT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_CM,
		ST_RD_OLD,
		ST_UPDATE,
		ST_DIV_AVG,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [CM_W-1:0]   ticks_q;
	logic [CM_W-1:0]   range_q;

	// Shared divider: dividend register shifts out at the top while the
	// quotient shifts in at the bottom.
	logic [ECHO_W-1:0] div_dvd_q;
	logic [CM_W-1:0]   div_rem_q;
	logic [CM_W-1:0]   div_dsr_q;
	logic [DCW-1:0]    div_cnt_q;
	logic [CM_W:0]     rem_shift;
	logic [CM_W+1:0]   rem_diff;
	logic              q_bit;
	logic [CM_W-1:0]   rem_next;
	logic              div_last;

	logic              bad_q;
	logic [CM_W-1:0]   cm_q;
	logic [CM_W-1:0]   cm_calc;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_next;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_next;
	logic              full;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W:0]    sum_wide;
	logic [SUM_W-1:0]  sum_next;
	logic [CM_W-1:0]   old_cm;

	logic [CM_W-1:0]   raw_out_q;
	logic [CM_W-1:0]   avg_out_q;
	logic              m_tvalid_q;
	logic              out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= edma_pkg::TICKS_RESET;
			range_q <= edma_pkg::RANGE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				edma_pkg::REG_TICKS_PER_CM: ticks_q <= cfg_data;
				edma_pkg::REG_MAX_RANGE_CM: range_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		rem_shift = {div_rem_q, div_dvd_q[ECHO_W-1]};
		rem_diff  = {1'b0, rem_shift} - {2'b00, div_dsr_q};
		q_bit     = ~rem_diff[CM_W+1];
		rem_next  = q_bit ? rem_diff[CM_W-1:0] : rem_shift[CM_W-1:0];
		div_last  = (div_cnt_q == DCW'(ECHO_W - 1));
	end

	// Distance check on the finished quotient.
	always_comb begin
		if (bad_q || (div_dvd_q > {{(ECHO_W-CM_W){1'b0}}, range_q})) begin
			cm_calc = '0;
		end else begin
			cm_calc = div_dvd_q[CM_W-1:0];
		end
	end

	// Running sum drops the entry about to be overwritten once the window is full.
	always_comb begin
		full       = (count_q == CNT_W'(WINDOW_LEN));
		count_next = full ? count_q : count_q + 1'b1;
		slot_next  = (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
		sum_wide   = {1'b0, sum_q} + {{(SUM_W-CM_W+1){1'b0}}, cm_q}
		           - (full ? {{(SUM_W-CM_W+1){1'b0}}, old_cm} : '0);
		sum_next   = sum_wide[SUM_W-1:0];
	end

	// The finished result moves into the output register once it is free.
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	edma_ram #(
		.WIDTH(CM_W),
		.DEPTH(WINDOW_LEN)
	) u_window (
		.clk   (clk),
		.we    (state_q == ST_UPDATE),
		.waddr (slot_q),
		.wdata (cm_q),
		.re    (state_q == ST_RD_OLD),
		.raddr (slot_q),
		.rdata (old_cm)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			div_dvd_q  <= '0;
			div_rem_q  <= '0;
			div_dsr_q  <= '0;
			div_cnt_q  <= '0;
			bad_q      <= 1'b0;
			cm_q       <= '0;
			slot_q     <= '0;
			count_q    <= '0;
			sum_q      <= '0;
			raw_out_q  <= '0;
			avg_out_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						div_dvd_q <= s_tdata;
						div_rem_q <= '0;
						div_dsr_q <= ticks_q;
						div_cnt_q <= '0;
						bad_q     <= (s_tdata == '0) || (ticks_q == '0);
						state_q   <= ST_DIV_CM;
					end
				end
				ST_DIV_CM, ST_DIV_AVG: begin
					div_dvd_q <= {div_dvd_q[ECHO_W-2:0], q_bit};
					div_rem_q <= rem_next;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_last) begin
						state_q <= (state_q == ST_DIV_CM) ? ST_RD_OLD : ST_DONE;
					end
				end
				ST_RD_OLD: begin
					cm_q    <= cm_calc;
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					sum_q     <= sum_next;
					count_q   <= count_next;
					slot_q    <= slot_next;
					div_dvd_q <= {{(ECHO_W-SUM_W){1'b0}}, sum_next};
					div_rem_q <= '0;
					div_dsr_q <= {{(CM_W-CNT_W){1'b0}}, count_next};
					div_cnt_q <= '0;
					state_q   <= ST_DIV_AVG;
				end
				ST_DONE: begin
					if (out_load) begin
						raw_out_q <= cm_q;
						avg_out_q <= div_dvd_q[CM_W-1:0];
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(edma_pkg::OUT_W-2*CM_W){1'b0}}, avg_out_q, raw_out_q};

endmodule
